>>> hw/rtl/sha_pkg.sv
// Package for the SHA-256 message digest block: types, round constants, functions.
// Depends on nothing; used by the top level, sha_datapath and sha_ctrl.
package sha_pkg;

  localparam int unsigned NumRounds = 64;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic load_byte;   // Write msg byte into the block buffer.
    logic pad_first;   // Write 0x80 at fill position and clear the tail.
    logic clear_all;   // Clear bytes 0..55 of the buffer (second padding block).
    logic put_length;  // Write the bit length into bytes 56..63.
    logic start_comp;  // Load working variables from the hash state.
    logic round_en;    // Run one round.
    logic finish_comp; // Add working variables into the hash state.
    logic restart;     // Reload the initial hash, clear counters.
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
  } sha_sts_t;

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t v, input int unsigned a);
    return (v >> a) | (v << (32 - a));
  endfunction

endpackage

>>> hw/rtl/sha_if.sv
// Valid/ready channel interfaces for the SHA-256 block.
// Standalone; used by the top level and its environment.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_valid;
  logic       end_of_message;
  modport source (output valid, msg_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, msg_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        digest_done;
  modport source (output valid, digest_word, word_number, digest_done, input ready);
  modport sink   (input valid, digest_word, word_number, digest_done, output ready);
endinterface

>>> hw/rtl/sha256_message_digest.sv
// Top level of the SHA-256 message digest block.
// Depends on sha_pkg, sha_if, sha_ctrl and sha_datapath.
//
//  channel | direction | fields
//  in_if   | sink      | msg_byte, byte_valid, end_of_message
//  out_if  | source    | digest_word, word_number, digest_done
//
// The byte that fills a 64-byte block starts a compression: one load, 64 rounds
// through a single shared round unit, one add into the hash state. Ending a
// message adds one or two padding compressions and then eight output words,
// one per cycle while the sink is ready. Reset restores the initial hash and
// clears the counters; no request is taken while work is running.
module sha256_message_digest import sha_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);

  sha_cmd_t   cmd;
  sha_sts_t   sts;
  logic [2:0] word;
  word_t      hash;

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .byte_valid_i(in_if.byte_valid),
    .eom_i       (in_if.end_of_message),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .word_o      (word),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sha_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .byte_i  (in_if.msg_byte),
    .rd_idx_i(word),
    .hash_o  (hash),
    .sts_o   (sts)
  );

  // The digest is read straight from the hash state register.
  assign out_if.digest_word = hash;
  assign out_if.word_number = word;
  assign out_if.digest_done = (word == 3'd7);

endmodule

>>> hw/rtl/sha_datapath.sv
// SHA-256 datapath: block buffer, schedule window, round unit, hash state, counters.
// Depends on sha_pkg; driven by sha_ctrl through sha_cmd_t.
module sha_datapath import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sha_cmd_t   cmd_i,
  input  logic [7:0] byte_i,
  input  logic [2:0] rd_idx_i,
  output word_t      hash_o,
  output sha_sts_t   sts_o
);

  // The block buffer holds sixteen big-endian words; byte 0 is the top byte of word 0.
  word_t       blk_q [16];
  word_t       w_q [16];
  word_t       v_q [8];
  word_t       h_q [8];
  logic [5:0]  fill_q, fill_d;
  logic [60:0] total_q, total_d;
  logic [5:0]  rnd_q;
  word_t       w_new, t1, t2;
  logic [63:0] bits;
  word_t       byte_w;
  word_t       pad_w [16];

  assign bits = {total_q, 3'b000};

  always_comb begin
    word_t w15, w2, g0, g1, s1, ch, s0, mj;
    w15 = w_q[1];
    w2  = w_q[14];
    g0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
    g1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
    if (rnd_q < 6'd16) begin
      w_new = blk_q[rnd_q[3:0]];
    end else begin
      w_new = w_q[0] + g0 + w_q[9] + g1;
    end
    s1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + round_k(rnd_q) + w_new;
    s0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = s0 + mj;
  end

  // Word at the fill position with the incoming byte merged in.
  always_comb begin
    byte_w = blk_q[fill_q[5:2]];
    byte_w[{~fill_q[1:0], 3'b000} +: 8] = byte_i;
  end

  // Padding image: 0x80 at the fill position, zeros after it, earlier bytes kept.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pad_w[i] = blk_q[i];
      for (int j = 0; j < 4; j++) begin
        if (6'(4 * i + j) == fill_q) pad_w[i][31 - 8 * j -: 8] = 8'h80;
        else if (6'(4 * i + j) > fill_q) pad_w[i][31 - 8 * j -: 8] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      blk_q[fill_q[5:2]] <= byte_w;
    end else if (cmd_i.pad_first) begin
      for (int i = 0; i < 16; i++) blk_q[i] <= pad_w[i];
    end else if (cmd_i.clear_all || cmd_i.put_length) begin
      for (int i = 0; i < 14; i++) begin
        if (cmd_i.clear_all) blk_q[i] <= '0;
      end
      blk_q[14] <= bits[63:32];
      blk_q[15] <= bits[31:0];
    end
  end

  // The schedule window shifts: w_q[0] is W[r-16], w_q[15] is W[r-1].
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_comp) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_comb begin
    fill_d  = fill_q;
    total_d = total_q;
    if (cmd_i.load_byte) begin
      fill_d  = fill_q + 6'd1;
      total_d = total_q + 61'd1;
    end
    if (cmd_i.restart) begin
      fill_d  = '0;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
      rnd_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(i[2:0]);
    end else begin
      fill_q  <= fill_d;
      total_q <= total_d;
      if (cmd_i.start_comp) rnd_q <= '0;
      else if (cmd_i.round_en) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_hash(i[2:0]);
      end else if (cmd_i.finish_comp) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  assign hash_o           = h_q[rd_idx_i];
  assign sts_o.fill       = fill_q;
  assign sts_o.round_last = (rnd_q == 6'(NumRounds - 1));

endmodule

>>> hw/rtl/sha_ctrl.sv
// SHA-256 controller: sequences byte loads, compressions, padding and digest output.
// Depends on sha_pkg; drives sha_datapath.
module sha_ctrl import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       byte_valid_i,
  input  logic       eom_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] word_o,
  input  sha_sts_t   sts_i,
  output sha_cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StPad   = 7'b0000010,
    StRound = 7'b0000100,
    StFin   = 7'b0001000,
    StLen   = 7'b0010000,
    StOut   = 7'b0100000,
    StStart = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic       eom_q, eom_d;     // Message ending: padding pending.
  logic       last_q, last_d;   // Current compression is the final one.
  logic       two_q, two_d;     // Padding needs an extra block.
  logic [2:0] word_q, word_d;
  logic       acc;

  assign in_ready_o  = (state_q == StIdle);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign word_o      = word_q;

  always_comb begin
    state_d = state_q;
    eom_d   = eom_q;
    last_d  = last_q;
    two_d   = two_q;
    word_d  = word_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (acc) begin
          cmd_o.load_byte = byte_valid_i;
          eom_d  = eom_i;
          last_d = 1'b0;
          if (byte_valid_i && sts_i.fill == 6'd63) begin
            state_d = StStart;
          end else if (eom_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        cmd_o.pad_first = 1'b1;
        eom_d = 1'b0;
        two_d = (sts_i.fill >= 6'd56);
        state_d = (sts_i.fill >= 6'd56) ? StStart : StLen;
      end
      StLen: begin
        if (two_q) cmd_o.clear_all = 1'b1;
        cmd_o.put_length = 1'b1;
        two_d  = 1'b0;
        last_d = 1'b1;
        state_d = StStart;
      end
      StStart: begin
        cmd_o.start_comp = 1'b1;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.round_last) state_d = StFin;
      end
      StFin: begin
        cmd_o.finish_comp = 1'b1;
        word_d = '0;
        if (last_q) state_d = StOut;
        else if (eom_q) state_d = StPad;
        else if (two_q) state_d = StLen;
        else state_d = StIdle;
      end
      StOut: begin
        if (out_ready_i) begin
          word_d = word_q + 3'd1;
          if (word_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            last_d  = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      eom_q   <= 1'b0;
      last_q  <= 1'b0;
      two_q   <= 1'b0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      eom_q   <= eom_d;
      last_q  <= last_d;
      two_q   <= two_d;
      word_q  <= word_d;
    end
  end

  a_out_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_q) else $error("digest shown before final block");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("accept while busy");
  a_round_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && sts_i.round_last) |=> state_q == StFin)
    else $error("round count overrun");
  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(word_q))
    else $error("word index moved under stall");

endmodule

>>> tb/sv/sha_tb_pkg.sv
// Testbench types for the SHA-256 message digest bench: request and digest word records.
// Depends on nothing; used by tb_sha256_message_digest.
package sha_tb_pkg;

  typedef struct {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } msg_req_t;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_done;
  } digest_out_t;

endpackage

>>> tb/sv/tb_sha256_message_digest.sv
// Self-checking bench for sha256_message_digest: random byte messages, SHA-256 predictor.
// Depends on sha_pkg, sha_if, sha_tb_pkg and the block's RTL.
module tb_sha256_message_digest;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;
  import sha_tb_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned LongHold = 400;

  logic clk_i;
  logic rst_ni;

  sha_in_if  req_if ();
  sha_out_if dig_if ();

  sha256_message_digest dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_if.sink),
    .out_if (dig_if.source)
  );

  // Predictor state: the running hash, the partial block and the byte count.
  logic [31:0] hash_st [8];
  logic [7:0]  blk_buf [64];
  logic [5:0]  fill_cnt;
  logic [60:0] byte_cnt;

  msg_req_t    pending_reqs [$];
  digest_out_t expected_words [$];

  int unsigned mismatches;
  int unsigned words_seen;
  int unsigned messages_sent;
  int unsigned cycle_cnt;
  bit          long_hold_req;
  bit          pause_req;
  bit          req_took;

  // The round constants are kept as a local table so that the predictor
  // stays independent of the RTL package.
  logic [31:0] k_tab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic [31:0] iv_tab [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // One full compression of blk_buf into hash_st.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
      end else begin
        w[r] = w[r-16] + w[r-7]
             + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
             + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
      end
    end
    {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + k_tab[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endtask

  task automatic restart_digest();
    foreach (hash_st[i]) hash_st[i] = iv_tab[i];
    fill_cnt = '0;
    byte_cnt = '0;
  endtask

  // Applies one accepted request and queues the digest words it produces.
  task automatic predict_digest(input msg_req_t rq);
    logic [63:0] bit_len;
    digest_out_t dw;
    if (rq.byte_valid) begin
      blk_buf[fill_cnt] = rq.msg_byte;
      fill_cnt++;
      byte_cnt++;
      if (fill_cnt == 0) compress_block();
    end
    if (rq.end_of_message) begin
      blk_buf[fill_cnt] = 8'h80;
      for (int i = int'(fill_cnt) + 1; i < 64; i++) blk_buf[i] = 8'h00;
      if (fill_cnt >= 56) begin
        compress_block();
        foreach (blk_buf[i]) blk_buf[i] = 8'h00;
      end
      bit_len = {byte_cnt, 3'b000};
      for (int i = 0; i < 8; i++) blk_buf[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.digest_word = hash_st[i];
        dw.word_number = 3'(i);
        dw.digest_done = (i == 7);
        expected_words.push_back(dw);
      end
      restart_digest();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Queues one message of the given length with random content. A zero length
  // gives the empty message; mid_idle sprinkles idle requests inside it, and
  // late_end ends the message with a separate data-less request.
  task automatic queue_message(input int unsigned len, input bit late_end,
                               input bit mid_idle);
    msg_req_t rq;
    for (int unsigned i = 0; i < len; i++) begin
      if (mid_idle && $urandom_range(0, 7) == 0) begin
        rq.msg_byte = 8'($urandom);
        rq.byte_valid = 1'b0;
        rq.end_of_message = 1'b0;
        pending_reqs.push_back(rq);
      end
      rq.msg_byte = 8'($urandom);
      rq.byte_valid = 1'b1;
      rq.end_of_message = (i == len - 1) && !late_end;
      pending_reqs.push_back(rq);
    end
    if (len == 0 || late_end) begin
      rq.msg_byte = 8'($urandom);
      rq.byte_valid = 1'b0;
      rq.end_of_message = 1'b1;
      pending_reqs.push_back(rq);
    end
    messages_sent++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Clock and a single reset at time zero.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Records whether the request on offer was taken at this rising edge.
  always @(posedge clk_i) begin
    req_took <= rst_ni && req_if.valid && req_if.ready;
  end

  // Sender: bursts of random length separated by random gaps. A pause request
  // stops it offering new requests so the block can drain.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.msg_byte <= '0;
      req_if.byte_valid <= 1'b0;
      req_if.end_of_message <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_took) begin
        predict_digest(pending_reqs.pop_front());
      end
      if (req_if.valid && !req_took) begin
        // Hold the current request until it is taken.
      end else if (pause_req || pending_reqs.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) begin
          gap_left = $urandom_range(1, 12);
        end
        req_if.valid <= 1'b1;
        req_if.msg_byte <= pending_reqs[0].msg_byte;
        req_if.byte_valid <= pending_reqs[0].byte_valid;
        req_if.end_of_message <= pending_reqs[0].end_of_message;
      end
    end
  end

  // Receiver stall pattern: alternating free-running and choppy stretches,
  // plus one long hold that lets the block back up into its input.
  int unsigned hold_cnt;
  int unsigned phase_cnt;

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_if.ready <= 1'b0;
      hold_cnt = 0;
      phase_cnt = 0;
    end else begin
      phase_cnt++;
      if (long_hold_req && hold_cnt < LongHold) begin
        hold_cnt++;
        dig_if.ready <= 1'b0;
      end else if (phase_cnt[8]) begin
        dig_if.ready <= 1'b1;
      end else begin
        dig_if.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor: compares each accepted digest word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (dig_if.valid && dig_if.ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", dig_if.digest_word, '0);
        end else begin
          digest_out_t want;
          want = expected_words.pop_front();
          if (dig_if.digest_word !== want.digest_word)
            report_mismatch("digest_word", dig_if.digest_word, want.digest_word);
          if (dig_if.word_number !== want.word_number)
            report_mismatch("word_number", 32'(dig_if.word_number), 32'(want.word_number));
          if (dig_if.digest_done !== want.digest_done)
            report_mismatch("digest_done", 32'(dig_if.digest_done), 32'(want.digest_done));
        end
      end
    end
  end

  // Watchdog on the cycle counter.
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Timeout after %0d cycles, %0d words still expected",
             cycle_cnt, expected_words.size());
    $display("Some tests failed");
    $finish;
  end

  // Stimulus sequence and end of run.
  initial begin
    msg_req_t rq;
    mismatches = 0;
    words_seen = 0;
    messages_sent = 0;
    cycle_cnt = 0;
    long_hold_req = 0;
    pause_req = 0;
    restart_digest();
    foreach (blk_buf[i]) blk_buf[i] = 8'h00;

    @(posedge rst_ni);

    // Directed part: empty message, idle request first, one byte of each extreme,
    // end without data, and lengths around the one- and two-block padding split.
    rq = '{8'hff, 1'b0, 1'b0};
    pending_reqs.push_back(rq);
    queue_message(0, 0, 0);
    rq = '{8'h00, 1'b1, 1'b1};
    pending_reqs.push_back(rq);
    rq = '{8'hff, 1'b1, 1'b1};
    pending_reqs.push_back(rq);
    queue_message(3, 1, 0);
    wait_drained();

    // Lengths 56 and 64 cross the padding boundaries.
    queue_message(56, 0, 0);
    queue_message(64, 1, 0);
    wait_drained();

    // Long receiver hold while the sender keeps offering requests.
    long_hold_req = 1;
    for (int m = 0; m < 4; m++) queue_message($urandom_range(1, 6), 0, 0);
    wait_drained();

    // Pause the sender while a message is queued, then resume and wait for it to drain.
    pause_req = 1;
    queue_message($urandom_range(8, 16), $urandom_range(0, 1), 1);
    repeat (20) @(posedge clk_i);
    pause_req = 0;
    wait_drained();

    // Random short messages.
    while (messages_sent < 18) begin
      queue_message($urandom_range(0, 8), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 1));
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d messages (empty, one- and two-block padding, idle requests)",
             messages_sent);
    $display("Checked %0d digest words under sender gaps and receiver stalls", words_seen);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_if.sv
hw/rtl/sha_datapath.sv
hw/rtl/sha_ctrl.sv
hw/rtl/sha256_message_digest.sv
tb/sv/sha_tb_pkg.sv
tb/sv/tb_sha256_message_digest.sv
